FILE: rtl/w2s_pkg.sv
package w2s_pkg;

	// register map, index = byte address / 8
	localparam logic [2:0] REG_ROW0_XY = 3'd0;
	localparam logic [2:0] REG_ROW0_ZT = 3'd1;
	localparam logic [2:0] REG_ROW1_XY = 3'd2;
	localparam logic [2:0] REG_ROW1_ZT = 3'd3;
	localparam logic [2:0] REG_ROWW_XY = 3'd4;
	localparam logic [2:0] REG_ROWW_ZT = 3'd5;
	localparam logic [2:0] REG_SCREEN_W = 3'd6;
	localparam logic [2:0] REG_SCREEN_H = 3'd7;
	localparam int NUM_REGS = 8;

	localparam int SIZE_W = 14;
	localparam int PIX_W = 16;
	// quotient bits resolved by the divider chain
	localparam int QUO_W = 16;

	localparam logic [SIZE_W-1:0] RST_SCREEN_W = 14'd1920;
	localparam logic [SIZE_W-1:0] RST_SCREEN_H = 14'd1080;

	localparam logic signed [PIX_W-1:0] PIX_MAX = 16'sh7fff;
	localparam logic signed [PIX_W-1:0] PIX_MIN = -16'sh8000;

endpackage

FILE: rtl/world_to_screen_projection_core.sv
// Pipeline: 6 arithmetic stages, 16 one-bit divider stages and an output
// register.
// Throughput: one point per cycle; the whole pipeline holds while a result
// waits at the output.
// Reset: arst_n clears all valid bits and loads the matrix with zeros and the
// viewport with 1920 x 1080.
module world_to_screen_projection_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	// input points
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // screen_x [15:0], screen_y [31:16]
	output logic        m_tuser    // visible
);
	import w2s_pkg::*;

	localparam int PW = 64 - FRAC_BITS;      // floored product width
	localparam int DW = PW + 2;              // dot product width
	localparam int MW = SIZE_W + DW + 1;     // size times magnitude
	localparam int NW = MW + 1;              // dividend width
	localparam int TH_INT = ((1 << FRAC_BITS) + 500) / 1000;
	localparam logic signed [DW-1:0] W_TH = DW'(TH_INT);

	typedef struct packed {
		logic [NW-1:0]    rem;
		logic [QUO_W-1:0] q;
		logic             neg;
		logic             ovf;
	} lane_t;

	typedef struct packed {
		logic          vis;
		logic [DW:0]   den;
		lane_t         x;
		lane_t         y;
	} dstage_t;

	// configuration registers
	logic [63:0] cfg_q [NUM_REGS];
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = cfg_q[paddr[5:3]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(REG_SCREEN_W); i++) begin
				cfg_q[i] <= '0;
			end
			cfg_q[REG_SCREEN_W] <= 64'(RST_SCREEN_W);
			cfg_q[REG_SCREEN_H] <= 64'(RST_SCREEN_H);
		end else if (cfg_wr) begin
			if (paddr[5:3] == REG_SCREEN_W || paddr[5:3] == REG_SCREEN_H) begin
				cfg_q[paddr[5:3]] <= 64'(pwdata[SIZE_W-1:0]);
			end else begin
				cfg_q[paddr[5:3]] <= pwdata;
			end
		end
	end

	// global advance: move when the output slot is free or being taken
	logic en;
	logic m_tvalid_q;
	assign en = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// stage 1: nine coefficient products
	logic signed [31:0] px, py, pz;
	logic signed [63:0] prod_s1 [3][3];
	logic               vld_s1;

	assign px = signed'(s_tdata[31:0]);
	assign py = signed'(s_tdata[63:32]);
	assign pz = signed'(s_tdata[95:64]);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s1[r][0] <= 64'(signed'(cfg_q[2*r][31:0])) * 64'(px);
				prod_s1[r][1] <= 64'(signed'(cfg_q[2*r][63:32])) * 64'(py);
				prod_s1[r][2] <= 64'(signed'(cfg_q[2*r+1][31:0])) * 64'(pz);
			end
		end
	end

	// stage 2: floor each product to FRAC_BITS and add the translation
	logic signed [DW-1:0] dot_s2 [3];
	logic                 vld_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				dot_s2[r] <= DW'(PW'(prod_s1[r][0] >>> FRAC_BITS))
					+ DW'(PW'(prod_s1[r][1] >>> FRAC_BITS))
					+ DW'(PW'(prod_s1[r][2] >>> FRAC_BITS))
					+ DW'(signed'(cfg_q[2*r+1][63:32]));
			end
		end
	end

	// stage 3: threshold test, numerators and their magnitudes
	logic signed [DW:0] bx, by;
	logic [DW:0]        mbx_s3, mby_s3;
	logic               nbx_s3, nby_s3, vis_s3, vld_s3;
	logic signed [DW-1:0] w_s3;

	assign bx = (DW+1)'(dot_s2[2]) + (DW+1)'(dot_s2[0]);
	assign by = (DW+1)'(dot_s2[2]) - (DW+1)'(dot_s2[1]);

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s3 <= dot_s2[2] > W_TH;
			w_s3   <= dot_s2[2];
			nbx_s3 <= bx[DW];
			nby_s3 <= by[DW];
			mbx_s3 <= bx[DW] ? (DW+1)'(-bx) : (DW+1)'(bx);
			mby_s3 <= by[DW] ? (DW+1)'(-by) : (DW+1)'(by);
		end
	end

	// stage 4: scale magnitudes by the viewport size
	logic [MW-1:0]        sbx_s4, sby_s4;
	logic                 nbx_s4, nby_s4, vis_s4, vld_s4;
	logic signed [DW-1:0] w_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			sbx_s4 <= MW'(cfg_q[REG_SCREEN_W][SIZE_W-1:0]) * MW'(mbx_s3);
			sby_s4 <= MW'(cfg_q[REG_SCREEN_H][SIZE_W-1:0]) * MW'(mby_s3);
			nbx_s4 <= nbx_s3;
			nby_s4 <= nby_s3;
			vis_s4 <= vis_s3;
			w_s4   <= w_s3;
		end
	end

	// stage 5: add or remove the half pixel term (x adds w, y removes w)
	logic [NW-1:0] magx_s5, magy_s5, wext;
	logic          negx_s5, negy_s5, vis_s5, vld_s5;
	logic [DW:0]   den_s5;

	assign wext = NW'(unsigned'(w_s4));

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s5 <= vis_s4;
			den_s5 <= (DW+1)'(unsigned'(w_s4)) << 1;
			// x: numerator s*b + w
			if (!nbx_s4) begin
				magx_s5 <= NW'(sbx_s4) + wext;
				negx_s5 <= 1'b0;
			end else if (NW'(sbx_s4) >= wext) begin
				magx_s5 <= NW'(sbx_s4) - wext;
				negx_s5 <= 1'b1;
			end else begin
				magx_s5 <= wext - NW'(sbx_s4);
				negx_s5 <= 1'b0;
			end
			// y: numerator s*b - w
			if (nby_s4) begin
				magy_s5 <= NW'(sby_s4) + wext;
				negy_s5 <= 1'b1;
			end else if (NW'(sby_s4) >= wext) begin
				magy_s5 <= NW'(sby_s4) - wext;
				negy_s5 <= 1'b0;
			end else begin
				magy_s5 <= wext - NW'(sby_s4);
				negy_s5 <= 1'b1;
			end
		end
	end

	// stage 6: flag quotients too large for the divider chain
	dstage_t div_s [QUO_W+1];
	logic    div_vld_s [QUO_W+1];
	logic [DW+QUO_W:0] den_top;

	assign den_top = (DW+QUO_W+1)'(den_s5) << QUO_W;

	// one restoring quotient bit of both lanes
	function automatic dstage_t div_step(dstage_t d, int b);
		dstage_t       n;
		logic [NW-1:0] dsh;
		n   = d;
		dsh = NW'(d.den) << b;
		if (d.x.rem >= dsh) begin
			n.x.rem  = d.x.rem - dsh;
			n.x.q[b] = 1'b1;
		end
		if (d.y.rem >= dsh) begin
			n.y.rem  = d.y.rem - dsh;
			n.y.q[b] = 1'b1;
		end
		return n;
	endfunction

	// stages 7..22: one restoring quotient bit per stage, highest bit first
	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].vis   <= vis_s5;
			div_s[0].den   <= den_s5;
			div_s[0].x.rem <= magx_s5;
			div_s[0].x.q   <= '0;
			div_s[0].x.neg <= negx_s5;
			div_s[0].x.ovf <= (DW+QUO_W+1)'(magx_s5) >= den_top;
			div_s[0].y.rem <= magy_s5;
			div_s[0].y.q   <= '0;
			div_s[0].y.neg <= negy_s5;
			div_s[0].y.ovf <= (DW+QUO_W+1)'(magy_s5) >= den_top;
			for (int k = 0; k < QUO_W; k++) begin
				div_s[k+1] <= div_step(div_s[k], QUO_W - 1 - k);
			end
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			for (int i = 0; i <= QUO_W; i++) begin
				div_vld_s[i] <= 1'b0;
			end
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			vld_s1       <= s_tvalid;
			vld_s2       <= vld_s1;
			vld_s3       <= vld_s2;
			vld_s4       <= vld_s3;
			vld_s5       <= vld_s4;
			div_vld_s[0] <= vld_s5;
			for (int i = 1; i <= QUO_W; i++) begin
				div_vld_s[i] <= div_vld_s[i-1];
			end
			m_tvalid_q <= div_vld_s[QUO_W];
		end
	end

	// output register: saturate and zero the invisible points
	function automatic logic signed [PIX_W-1:0] sat_pix(lane_t l);
		logic signed [PIX_W-1:0] r;
		if (l.neg) begin
			r = (l.ovf || l.q[QUO_W-1]) ? PIX_MIN : PIX_W'(-signed'({1'b0, l.q}));
		end else begin
			r = (l.ovf || l.q[QUO_W-1]) ? PIX_MAX : signed'(l.q);
		end
		return r;
	endfunction

	logic [31:0] m_tdata_q;
	logic        m_tuser_q;
	dstage_t     dl;
	logic        dl_vld;

	assign dl     = div_s[QUO_W];
	assign dl_vld = div_vld_s[QUO_W];

	always_ff @(posedge clk) begin
		if (en) begin
			m_tuser_q <= dl.vis;
			if (dl.vis) begin
				m_tdata_q <= {sat_pix(dl.y), sat_pix(dl.x)};
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// invisible points carry zero coordinates
	a_invis_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 32'd0)
		else $error("invisible point with nonzero coordinates");

	// a finished division reaches the output when the pipe advances
	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && dl_vld |=> m_tvalid)
		else $error("divider result lost");

	// quotient overflow on a positive x saturates high
	a_sat_x: assert property (@(posedge clk) disable iff (!arst_n)
		en && dl_vld && dl.vis && dl.x.ovf && !dl.x.neg |=> m_tdata[15:0] == PIX_MAX)
		else $error("x overflow not saturated");

	// quotient overflow on a negative y saturates low
	a_sat_y: assert property (@(posedge clk) disable iff (!arst_n)
		en && dl_vld && dl.vis && dl.y.ovf && dl.y.neg |=> m_tdata[31:16] == PIX_MIN)
		else $error("y overflow not saturated");

endmodule

FILE: tb/tb_world_to_screen_projection_core.sv
`timescale 1ns / 1ps

module tb_world_to_screen_projection_core;
	import w2s_pkg::*;

	localparam int FRAC = 16;
	localparam int W_MIN = ((1 << FRAC) + 500) / 1000;
	localparam int ONE = 1 << FRAC;

	typedef struct packed {
		logic vis;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
	} pixel_t;

	// Holds a copy of the registers and the projected pixels still to come out
	class projection_board;
		logic [63:0] regs [NUM_REGS];
		pixel_t pending [$];
		int errors;
		int seen;
		int visible_seen;

		function new();
			for (int i = 0; i < NUM_REGS; i++)
				regs[i] = '0;
			regs[REG_SCREEN_W] = 64'(RST_SCREEN_W);
			regs[REG_SCREEN_H] = 64'(RST_SCREEN_H);
		endfunction

		function void set_reg(logic [2:0] idx, logic [63:0] val);
			if (idx == REG_SCREEN_W || idx == REG_SCREEN_H)
				regs[idx] = {50'd0, val[13:0]};
			else
				regs[idx] = val;
		endfunction

		task report(string msg);
			$display("mismatch @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// dot product of one matrix row with [p,1], each product floored to FRAC bits
		function automatic logic signed [63:0] row_dot(logic [63:0] xy, logic [63:0] zt,
				logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz);
			logic signed [63:0] a, b, c, t;
			a = 64'($signed(xy[31:0])) * 64'(px);
			b = 64'($signed(xy[63:32])) * 64'(py);
			c = 64'($signed(zt[31:0])) * 64'(pz);
			t = 64'($signed(zt[63:32]));
			return (a >>> FRAC) + (b >>> FRAC) + (c >>> FRAC) + t;
		endfunction

		// trunc((s*b + e*w) / 2w), saturated to 16-bit signed
		function automatic logic signed [15:0] to_pixel(logic signed [63:0] bv,
				logic signed [63:0] wv, int e, logic [13:0] s);
			logic signed [127:0] num, den, q, sw;
			sw = {114'd0, s};
			num = sw * bv + wv * e;
			den = wv * 2;
			q = num / den;
			if (q > 32767)
				return PIX_MAX;
			if (q < -32768)
				return PIX_MIN;
			return q[15:0];
		endfunction

		function void note_point(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			logic signed [63:0] w, cx, cy;
			pixel_t r;
			w = row_dot(regs[REG_ROWW_XY], regs[REG_ROWW_ZT], px, py, pz);
			r = '0;
			if (w > W_MIN) begin
				cx = row_dot(regs[REG_ROW0_XY], regs[REG_ROW0_ZT], px, py, pz);
				cy = row_dot(regs[REG_ROW1_XY], regs[REG_ROW1_ZT], px, py, pz);
				r.vis = 1'b1;
				r.sx = to_pixel(w + cx, w, 1, regs[REG_SCREEN_W][13:0]);
				r.sy = to_pixel(w - cy, w, -1, regs[REG_SCREEN_H][13:0]);
			end
			pending.push_back(r);
		endfunction

		task check_pixel(logic vis, logic [31:0] data);
			pixel_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result vis=%0b data=%h", vis, data));
				return;
			end
			want = pending.pop_front();
			seen++;
			if (vis)
				visible_seen++;
			if (vis !== want.vis)
				report($sformatf("visible %0b, want %0b", vis, want.vis));
			if ($signed(data[15:0]) !== want.sx)
				report($sformatf("screen_x %0d, want %0d", $signed(data[15:0]), want.sx));
			if ($signed(data[31:16]) !== want.sy)
				report($sformatf("screen_y %0d, want %0d", $signed(data[31:16]), want.sy));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [5:0] paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic pready;
	logic s_tvalid, s_tready;
	logic [95:0] s_tdata;   // point_x [31:0], point_y [63:32], point_z [95:64]
	logic m_tvalid, m_tready;
	logic [31:0] m_tdata;   // screen_x [15:0], screen_y [31:16]
	logic m_tuser;          // visible

	projection_board board;
	int send_idle_pct;
	int stall_pct;
	int points_sent;

	world_to_screen_projection_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// bound the run
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	// accept and check results; stall at random
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_pixel(m_tuser, m_tdata);
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task apb_write(logic [2:0] idx, logic [63:0] val);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 3'b000};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		board.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// drain the pipeline before touching the registers
	task wait_drained();
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {pz, py, px};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_point(px, py, pz);
		points_sent++;
	endtask

	task send_done();
		@(negedge clk);
		s_tvalid <= 1'b0;
	endtask

	function automatic logic [31:0] span(int r);
		return $urandom_range(0, 2 * r) - r;
	endfunction

	function automatic logic [31:0] coef(logic bias_pos);
		if ($urandom_range(9) < 3)
			return $urandom;
		if (bias_pos)
			return $urandom_range(0, 2 * ONE);
		return span(2 * ONE);
	endfunction

	function automatic logic [31:0] coord(logic depth);
		if ($urandom_range(9) < 3)
			return $urandom;
		if (depth)
			return span(200 * ONE) + 150 * ONE;
		return span(100 * ONE);
	endfunction

	task load_matrix(logic [31:0] m [12]);
		apb_write(REG_ROW0_XY, {m[1], m[0]});
		apb_write(REG_ROW0_ZT, {m[3], m[2]});
		apb_write(REG_ROW1_XY, {m[5], m[4]});
		apb_write(REG_ROW1_ZT, {m[7], m[6]});
		apb_write(REG_ROWW_XY, {m[9], m[8]});
		apb_write(REG_ROWW_ZT, {m[11], m[10]});
	endtask

	initial begin
		logic [31:0] m [12];
		int sizes [6][2];
		board = new();
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_tvalid = 1'b0; s_tdata = '0; m_tready = 1'b1;
		send_idle_pct = 0; stall_pct = 0; points_sent = 0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// zero matrix after reset: w is zero, nothing visible
		send_point(32'h7fffffff, 32'h80000000, 32'h12345678);
		send_done();
		wait_drained();

		// plain perspective: x, y straight through, w = z
		m = '{ONE, 0, 0, 0, 0, ONE, 0, 0, 0, 0, ONE, 0};
		load_matrix(m);
		send_point(0, 0, 0);
		send_point(0, 0, W_MIN);
		send_point(0, 0, W_MIN + 1);
		send_point(0, 0, 32'hffff0000);
		send_point(0, 0, ONE);
		send_point(ONE, ONE, ONE);
		send_point(32'hffff0000, 32'hffff0000, ONE);
		send_point(32'h7fffffff, 32'h7fffffff, ONE);
		send_point(32'h80000000, 32'h80000000, ONE);
		send_point(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_point(32'hffffffff, 32'hffffffff, 32'h80000000);
		send_point(ONE / 2, 32'hffff8000, 4 * ONE);
		send_point(3 * ONE, 32'hfffe0000, W_MIN + 1);
		send_done();
		wait_drained();

		// extreme viewport sizes, including zero and the full 14-bit value
		apb_write(REG_SCREEN_W, 64'd16383);
		apb_write(REG_SCREEN_H, 64'd0);
		send_point(ONE / 4, ONE / 4, ONE);
		send_point(32'h80000000, 32'h7fffffff, ONE);
		send_point(0, 0, ONE);
		send_done();
		wait_drained();
		apb_write(REG_SCREEN_W, 64'd1);
		apb_write(REG_SCREEN_H, 64'd1);
		send_point(ONE / 4, ONE / 4, ONE);
		send_point(32'hffffc000, 32'hffffc000, ONE);
		send_done();
		wait_drained();

		// random phases over several matrices and viewports
		sizes = '{'{1920, 1080}, '{8192, 8192}, '{1, 1}, '{16383, 0}, '{640, 480},
			'{0, 16383}};
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 79; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 79; end
				default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			for (int i = 0; i < 12; i++)
				m[i] = coef(i == 10);
			// keep the w row mostly looking down +z
			if ($urandom_range(3) != 0) begin
				m[8] = span(ONE / 8);
				m[9] = span(ONE / 8);
				m[11] = span(ONE);
			end
			load_matrix(m);
			apb_write(REG_SCREEN_W, 64'(sizes[ph][0]));
			apb_write(REG_SCREEN_H, 64'(sizes[ph][1]));
			for (int i = 0; i < 145; i++) begin
				if (ph == 3 && i == 70) begin
					// hold off the sender until the pipeline runs empty
					send_done();
					while (board.pending.size() != 0)
						@(posedge clk);
				end
				send_point(coord(0), coord(0), coord(1));
			end
			send_done();
			wait_drained();
		end

		board.errors += board.pending.size();
		$display("covered %0d points (%0d visible) over several register settings,",
			points_sent, board.visible_seen);
		$display("threshold edges, saturation, extreme viewports and four idle patterns");
		if (board.errors == 0 && board.seen == points_sent)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
